/* rtl/core/line_rasterizer_3d_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the 3D line rasterizer
// Concurrent check wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_3D_TOP_MACROS_SVH
`define LINE_RASTERIZER_3D_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge out of reset
`define LR3_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// cond must never be true out of reset
`define LR3_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define LR3_ASSERT(name, clk, rst, prop, msg)
`define LR3_NEVER(name, clk, rst, cond, msg)

`endif

`endif

/* rtl/core/lr3_pkg.sv */
// ----------------------------------------------------------------------------
// lr3_pkg
// Shared types and constants of the 3D line rasterizer.
// ----------------------------------------------------------------------------
package lr3_pkg;

  // item kinds on the input stream (tuser)
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } cmd_t;

  // dominant axis of a line
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // per-line stepping control
  typedef struct packed {
    logic [2:0] step_signs;  // bit i set: axis i steps down
    axis_t      major;
  } ctl_t;

  // config register indexes
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DEPTH_NEAR    = 2'd2;
  localparam logic [1:0] REG_DEPTH_FAR     = 2'd3;

  localparam int SCREEN_BITS = 13;
  localparam int DEPTH_BITS  = 15;

  localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = 13'd800;
  localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 13'd800;
  localparam logic [DEPTH_BITS-1:0]  DEPTH_NEAR_RST    = 15'd1;
  localparam logic [DEPTH_BITS-1:0]  DEPTH_FAR_RST     = 15'd100;

endpackage

/* rtl/core/lr3_setup.sv */
// ----------------------------------------------------------------------------
// lr3_setup
// Line setup: deltas, dominant axis, doubled deltas and initial error terms.
// ----------------------------------------------------------------------------
module lr3_setup import lr3_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] start_z,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] end_z,
  output ctl_t                         ctl,
  output logic        [COORD_BITS:0]   twice_dx,
  output logic        [COORD_BITS:0]   twice_dy,
  output logic        [COORD_BITS:0]   twice_dz,
  output logic signed [COORD_BITS+2:0] err_first,
  output logic signed [COORD_BITS+2:0] err_second,
  output logic        [COORD_BITS-1:0] length
);

  localparam int C = COORD_BITS;

  logic signed [C:0]   dx, dy, dz, ndx, ndy, ndz;
  logic        [C-1:0] lx, ly, lz, l_maj;
  logic        [C:0]   t_m1, t_m2;

  // deltas, one bit wider than a coordinate
  assign dx  = {end_x[C-1], end_x} - {start_x[C-1], start_x};
  assign dy  = {end_y[C-1], end_y} - {start_y[C-1], start_y};
  assign dz  = {end_z[C-1], end_z} - {start_z[C-1], start_z};
  assign ndx = -dx;
  assign ndy = -dy;
  assign ndz = -dz;

  // magnitudes always fit in C bits
  assign lx = dx[C] ? ndx[C-1:0] : dx[C-1:0];
  assign ly = dy[C] ? ndy[C-1:0] : dy[C-1:0];
  assign lz = dz[C] ? ndz[C-1:0] : dz[C-1:0];

  assign twice_dx = {lx, 1'b0};
  assign twice_dy = {ly, 1'b0};
  assign twice_dz = {lz, 1'b0};

  always_comb begin
    ctl.step_signs = {dz[C], dy[C], dx[C]};
    // ties go to x, then y
    if (lx >= ly && lx >= lz) begin
      ctl.major = AXIS_X;
      l_maj     = lx;
      t_m1      = twice_dy;
      t_m2      = twice_dz;
    end else if (ly >= lz) begin
      ctl.major = AXIS_Y;
      l_maj     = ly;
      t_m1      = twice_dx;
      t_m2      = twice_dz;
    end else begin
      ctl.major = AXIS_Z;
      l_maj     = lz;
      t_m1      = twice_dy;
      t_m2      = twice_dx;
    end
  end

  assign err_first  = $signed({2'b00, t_m1}) - $signed({3'b000, l_maj});
  assign err_second = $signed({2'b00, t_m2}) - $signed({3'b000, l_maj});
  assign length     = l_maj;

endmodule

/* rtl/core/lr3_step.sv */
// ----------------------------------------------------------------------------
// lr3_step
// One Bresenham step plus screen and depth clipping of the current pixel.
// ----------------------------------------------------------------------------
module lr3_step import lr3_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic signed [COORD_BITS-1:0] cur_x,
  input  logic signed [COORD_BITS-1:0] cur_y,
  input  logic signed [COORD_BITS-1:0] cur_z,
  input  logic signed [COORD_BITS+2:0] err_first,
  input  logic signed [COORD_BITS+2:0] err_second,
  input  logic        [COORD_BITS:0]   twice_dx,
  input  logic        [COORD_BITS:0]   twice_dy,
  input  logic        [COORD_BITS:0]   twice_dz,
  input  ctl_t                         ctl,
  input  logic        [COORD_BITS-1:0] pixels_left,
  input  logic        [SCREEN_BITS-1:0] screen_width,
  input  logic        [SCREEN_BITS-1:0] screen_height,
  input  logic        [DEPTH_BITS-1:0]  depth_near,
  input  logic        [DEPTH_BITS-1:0]  depth_far,
  output logic signed [COORD_BITS-1:0] cur_x_next,
  output logic signed [COORD_BITS-1:0] cur_y_next,
  output logic signed [COORD_BITS-1:0] cur_z_next,
  output logic signed [COORD_BITS+2:0] err_first_next,
  output logic signed [COORD_BITS+2:0] err_second_next,
  output logic        [COORD_BITS-1:0] pixels_left_next,
  output logic                         in_view,
  output logic                         last_pixel
);

  localparam int C  = COORD_BITS;
  localparam int XW = ((C > SCREEN_BITS) ? C : SCREEN_BITS) + 1;
  localparam int ZW = ((C > DEPTH_BITS) ? C : DEPTH_BITS) + 1;
  localparam logic [C-1:0] UNIT = C'(1);

  logic          e1_pos, e2_pos;
  logic          inc_x, inc_y, inc_z;
  logic [C:0]    t_maj, t_m1, t_m2;
  logic signed [XW-1:0] xe, ye, we, he;
  logic signed [ZW-1:0] ze, ne, fe;

  assign e1_pos = !err_first[C+2]  && (err_first  != '0);
  assign e2_pos = !err_second[C+2] && (err_second != '0);

  always_comb begin
    t_maj = twice_dz;
    t_m1  = twice_dy;
    t_m2  = twice_dx;
    inc_x = e2_pos;
    inc_y = e1_pos;
    inc_z = 1'b1;
    unique case (ctl.major)
      AXIS_X: begin
        t_maj = twice_dx;
        t_m1  = twice_dy;
        t_m2  = twice_dz;
        inc_x = 1'b1;
        inc_y = e1_pos;
        inc_z = e2_pos;
      end
      AXIS_Y: begin
        t_maj = twice_dy;
        t_m1  = twice_dx;
        t_m2  = twice_dz;
        inc_x = e1_pos;
        inc_y = 1'b1;
        inc_z = e2_pos;
      end
      default: begin
        // z major, the defaults above
      end
    endcase
  end

  assign err_first_next = err_first
                        - (e1_pos ? $signed({2'b00, t_maj}) : '0)
                        + $signed({2'b00, t_m1});
  assign err_second_next = err_second
                         - (e2_pos ? $signed({2'b00, t_maj}) : '0)
                         + $signed({2'b00, t_m2});

  assign cur_x_next = inc_x ? (ctl.step_signs[0] ? cur_x - UNIT : cur_x + UNIT) : cur_x;
  assign cur_y_next = inc_y ? (ctl.step_signs[1] ? cur_y - UNIT : cur_y + UNIT) : cur_y;
  assign cur_z_next = inc_z ? (ctl.step_signs[2] ? cur_z - UNIT : cur_z + UNIT) : cur_z;

  assign pixels_left_next = pixels_left - UNIT;
  assign last_pixel       = (pixels_left == '0);

  // clipping, compared at a common signed width
  assign xe = {{(XW-C){cur_x[C-1]}}, cur_x};
  assign ye = {{(XW-C){cur_y[C-1]}}, cur_y};
  assign we = {{(XW-SCREEN_BITS){1'b0}}, screen_width};
  assign he = {{(XW-SCREEN_BITS){1'b0}}, screen_height};
  assign ze = {{(ZW-C){cur_z[C-1]}}, cur_z};
  assign ne = {{(ZW-DEPTH_BITS){1'b0}}, depth_near};
  assign fe = {{(ZW-DEPTH_BITS){1'b0}}, depth_far};

  assign in_view = !cur_x[C-1] && (xe < we) &&
                   !cur_y[C-1] && (ye < he) &&
                   (ze >= ne) && (ze <= fe);

endmodule

/* rtl/core/line_rasterizer_3d_top.sv */
// ----------------------------------------------------------------------------
// line_rasterizer_3d_top
// Three-axis Bresenham line generator with screen and depth clipping.
// ----------------------------------------------------------------------------
// A start item (tuser = 0) loads two endpoints and a color and emits nothing;
// each next item (tuser = 1) then emits one pixel, endpoints included, so a
// line gives (dominant length + 1) pixels with tlast on the final one. A next
// item with no line in progress is consumed and emits nothing; a start item
// replaces any line in progress. The block takes one item per clock unless a
// next item that would emit a pixel waits on a stalled consumer. An item
// sits in the input register while the setup or step logic works on it,
// and its pixel is registered in the output register when the item is
// consumed. While a pixel waits on a stalled consumer the input register
// still takes one more item; a next item that would emit a pixel then waits
// there, while start items and next items with no line in progress keep
// flowing. Screen and depth limits come from the config port and should only
// be changed while no line is running.
`include "line_rasterizer_3d_top_macros.svh"

module line_rasterizer_3d_top import lr3_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // tdata, low bit up: start_x, start_y, start_z, end_x, end_y, end_z,
  // argb_color, zero fill to whole bytes
  input  logic [((6*COORD_BITS+32+7)/8)*8-1:0] s_tdata,
  // tuser: cmd
  input  logic                   s_tuser,
  // output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // tdata, low bit up: pixel_x, pixel_y, pixel_z, pixel_color, zero fill
  output logic [((3*COORD_BITS+32+7)/8)*8-1:0] m_tdata,
  // tuser: in_view
  output logic                   m_tuser,
  // tlast: last_pixel
  output logic                   m_tlast,
  // config write port
  input  logic                   cfg_wen,
  input  logic [1:0]             cfg_addr,
  input  logic [DEPTH_BITS-1:0]  cfg_wdata
);

  localparam int C     = COORD_BITS;
  localparam int IN_W  = 6*C + 32;
  localparam int OUT_W = ((3*C + 32 + 7) / 8) * 8;

  // ---- config registers ----
  logic [SCREEN_BITS-1:0] screen_width, screen_height;
  logic [DEPTH_BITS-1:0]  depth_near, depth_far;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
      depth_near    <= DEPTH_NEAR_RST;
      depth_far     <= DEPTH_FAR_RST;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_wdata[SCREEN_BITS-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_wdata[SCREEN_BITS-1:0];
        REG_DEPTH_NEAR:    depth_near    <= cfg_wdata;
        REG_DEPTH_FAR:     depth_far     <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  // ---- input register ----
  logic            in_valid;
  cmd_t            in_cmd;
  logic [IN_W-1:0] in_data;
  logic            advance;   // input register item is consumed this cycle
  logic            produce;   // input register item would emit a pixel if consumed
  logic            line_active;
  logic            out_valid;

  assign produce  = (in_cmd == CMD_NEXT) && line_active;
  assign advance  = in_valid && (!produce || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= cmd_t'(s_tuser);
      in_data <= s_tdata[IN_W-1:0];
    end
  end

  // ---- line setup ----
  ctl_t                set_ctl;
  logic        [C:0]   set_tdx, set_tdy, set_tdz;
  logic signed [C+2:0] set_err1, set_err2;
  logic        [C-1:0] set_len;

  lr3_setup #(.COORD_BITS(C)) u_setup (
    .start_x    (in_data[C-1:0]),
    .start_y    (in_data[2*C-1:C]),
    .start_z    (in_data[3*C-1:2*C]),
    .end_x      (in_data[4*C-1:3*C]),
    .end_y      (in_data[5*C-1:4*C]),
    .end_z      (in_data[6*C-1:5*C]),
    .ctl        (set_ctl),
    .twice_dx   (set_tdx),
    .twice_dy   (set_tdy),
    .twice_dz   (set_tdz),
    .err_first  (set_err1),
    .err_second (set_err2),
    .length     (set_len)
  );

  // ---- line state ----
  logic signed [C-1:0] cur_x, cur_y, cur_z;
  logic signed [C+2:0] err_first, err_second;
  logic        [C:0]   twice_dx, twice_dy, twice_dz;
  ctl_t                ctl;
  logic        [C-1:0] pixels_left;
  logic        [31:0]  held_color;

  logic signed [C-1:0] cur_x_next, cur_y_next, cur_z_next;
  logic signed [C+2:0] err_first_next, err_second_next;
  logic        [C-1:0] pixels_left_next;
  logic                step_view, step_last;

  lr3_step #(.COORD_BITS(C)) u_step (
    .cur_x            (cur_x),
    .cur_y            (cur_y),
    .cur_z            (cur_z),
    .err_first        (err_first),
    .err_second       (err_second),
    .twice_dx         (twice_dx),
    .twice_dy         (twice_dy),
    .twice_dz         (twice_dz),
    .ctl              (ctl),
    .pixels_left      (pixels_left),
    .screen_width     (screen_width),
    .screen_height    (screen_height),
    .depth_near       (depth_near),
    .depth_far        (depth_far),
    .cur_x_next       (cur_x_next),
    .cur_y_next       (cur_y_next),
    .cur_z_next       (cur_z_next),
    .err_first_next   (err_first_next),
    .err_second_next  (err_second_next),
    .pixels_left_next (pixels_left_next),
    .in_view          (step_view),
    .last_pixel       (step_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (advance) begin
      if (in_cmd == CMD_START) begin
        line_active <= 1'b1;
      end else if (produce && step_last) begin
        line_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_cmd == CMD_START) begin
      cur_x       <= in_data[C-1:0];
      cur_y       <= in_data[2*C-1:C];
      cur_z       <= in_data[3*C-1:2*C];
      err_first   <= set_err1;
      err_second  <= set_err2;
      twice_dx    <= set_tdx;
      twice_dy    <= set_tdy;
      twice_dz    <= set_tdz;
      ctl         <= set_ctl;
      pixels_left <= set_len;
      held_color  <= in_data[IN_W-1:6*C];
    end else if (advance && produce && !step_last) begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      cur_z       <= cur_z_next;
      err_first   <= err_first_next;
      err_second  <= err_second_next;
      pixels_left <= pixels_left_next;
    end
  end

  // ---- result register ----
  logic signed [C-1:0] out_x, out_y, out_z;
  logic        [31:0]  out_color;
  logic                out_view, out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produce) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      out_x     <= cur_x;
      out_y     <= cur_y;
      out_z     <= cur_z;
      out_color <= held_color;
      out_view  <= step_view;
      out_last  <= step_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({out_color, out_z, out_y, out_x});
  assign m_tuser  = out_view;
  assign m_tlast  = out_last;

  // ---- checks ----
  // doubled delta of the dominant axis is never below the others
  logic major_ok;
  always_comb begin
    unique case (ctl.major)
      AXIS_X:  major_ok = (twice_dx >= twice_dy) && (twice_dx >= twice_dz);
      AXIS_Y:  major_ok = (twice_dy >= twice_dx) && (twice_dy >= twice_dz);
      default: major_ok = (twice_dz >= twice_dx) && (twice_dz >= twice_dy);
    endcase
  end

  `LR3_NEVER(a_major_dominant, clk, rst, line_active && !major_ok, "major axis not dominant")
  `LR3_ASSERT(a_pixel_source, clk, rst, $rose(out_valid) |-> $past(advance && produce), "pixel without next item")
  `LR3_ASSERT(a_line_end, clk, rst, $fell(line_active) |-> out_valid && out_last, "line ended without last pixel")

endmodule

/* tb/line_rasterizer_3d_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer_3d_checker
// Watches the item streams and config port of the line rasterizer, traces
// each line on its own and compares every emitted pixel in order.
// ----------------------------------------------------------------------------
module line_rasterizer_3d_checker import lr3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [127:0]          s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [79:0]           m_tdata,
  input  logic                  m_tuser,
  input  logic                  m_tlast,
  input  logic                  cfg_wen,
  input  logic [1:0]            cfg_addr,
  input  logic [DEPTH_BITS-1:0] cfg_wdata,
  output int                    failures,
  output int                    pending
);

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [31:0] color;
    logic        in_view;
    logic        last;
  } pixel_t;

  // view limits
  int view_w, view_h, near_z, far_z;

  // line tracer state
  int          pos [3];
  int          twice [3];
  int          err_a, err_b;
  logic [2:0]  down;
  axis_t       major;
  int          steps_left;
  bit          busy;
  logic [31:0] color_hold;

  pixel_t expected_pixels [$];
  pixel_t got, want;
  int     pixel_count;

  function automatic int minor_a(axis_t maj);
    return (maj == AXIS_X) ? 1 : 0;
  endfunction

  function automatic int minor_b(axis_t maj);
    return (maj == AXIS_Z) ? 1 : 2;
  endfunction

  function automatic int unit_step(int a);
    return down[a] ? -1 : 1;
  endfunction

  task report_mismatch(input string field, input logic [31:0] seen, input logic [31:0] wanted);
    $display("ERROR: pixel %0d %s got %0h want %0h", pixel_count, field, seen, wanted);
    failures++;
  endtask

  task load_line(input logic [127:0] data);
    int from [3];
    int span [3];
    int mj;
    for (int i = 0; i < 3; i++) begin
      from[i] = $signed(data[16*i +: 16]);
      span[i] = int'($signed(data[48 + 16*i +: 16])) - from[i];
      down[i] = (span[i] < 0);
      if (span[i] < 0) span[i] = -span[i];
      pos[i]   = from[i];
      twice[i] = 2 * span[i];
    end
    // x wins ties with y or z, then y wins ties with z
    if (span[0] >= span[1] && span[0] >= span[2]) major = AXIS_X;
    else if (span[1] >= span[2])                  major = AXIS_Y;
    else                                          major = AXIS_Z;
    mj = int'(major);
    err_a      = twice[minor_a(major)] - span[mj];
    err_b      = twice[minor_b(major)] - span[mj];
    steps_left = span[mj];
    color_hold = data[127:96];
    busy       = 1'b1;
  endtask

  task step_line(output pixel_t px);
    int mj, ma, mb;
    px.x       = pos[0][15:0];
    px.y       = pos[1][15:0];
    px.z       = pos[2][15:0];
    px.color   = color_hold;
    px.in_view = pos[0] >= 0 && pos[0] < view_w && pos[1] >= 0 && pos[1] < view_h &&
                 pos[2] >= near_z && pos[2] <= far_z;
    px.last    = (steps_left == 0);
    if (px.last) begin
      busy = 1'b0;
    end else begin
      mj = int'(major);
      ma = minor_a(major);
      mb = minor_b(major);
      if (err_a > 0) begin
        pos[ma] += unit_step(ma);
        err_a   -= twice[mj];
      end
      if (err_b > 0) begin
        pos[mb] += unit_step(mb);
        err_b   -= twice[mj];
      end
      err_a += twice[ma];
      err_b += twice[mb];
      pos[mj] += unit_step(mj);
      steps_left--;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      view_w  = SCREEN_WIDTH_RST;
      view_h  = SCREEN_HEIGHT_RST;
      near_z  = DEPTH_NEAR_RST;
      far_z   = DEPTH_FAR_RST;
      busy    = 1'b0;
      expected_pixels.delete();
      pixel_count = 0;
    end else begin
      // outgoing pixel first: nothing accepted at this edge can show yet
      if (m_tvalid && m_tready) begin
        got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[79:48],
               m_tuser, m_tlast};
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected", 32'(got.x), 32'd0);
        end else begin
          want = expected_pixels.pop_front();
          if (got.x !== want.x)             report_mismatch("x", 32'(got.x), 32'(want.x));
          if (got.y !== want.y)             report_mismatch("y", 32'(got.y), 32'(want.y));
          if (got.z !== want.z)             report_mismatch("z", 32'(got.z), 32'(want.z));
          if (got.color !== want.color)     report_mismatch("color", got.color, want.color);
          if (got.in_view !== want.in_view) report_mismatch("in_view", 32'(got.in_view),
                                                            32'(want.in_view));
          if (got.last !== want.last)       report_mismatch("last", 32'(got.last),
                                                            32'(want.last));
        end
        pixel_count++;
      end
      if (s_tvalid && s_tready) begin
        if (cmd_t'(s_tuser) == CMD_START) begin
          load_line(s_tdata);
        end else if (busy) begin
          step_line(want);
          expected_pixels.insert(expected_pixels.size(), want);
        end
      end
      if (cfg_wen) begin
        case (cfg_addr)
          REG_SCREEN_WIDTH:  view_w = cfg_wdata[SCREEN_BITS-1:0];
          REG_SCREEN_HEIGHT: view_h = cfg_wdata[SCREEN_BITS-1:0];
          REG_DEPTH_NEAR:    near_z = cfg_wdata;
          REG_DEPTH_FAR:     far_z  = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives lines through the 3D line rasterizer under bursty input and a
// stalling consumer, across several clip settings; the checker judges pixels.
// ----------------------------------------------------------------------------
module testbench import lr3_pkg::*; ();

  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_WAIT  = 16;    // covers the input and output registers plus slack
  localparam int PHASE_ITEMS = 130;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [127:0]          s_tdata = '0;   // sx, sy, sz, ex, ey, ez, argb (low bit up)
  logic                  s_tuser = 1'b0; // cmd
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [79:0]           m_tdata;        // x, y, z, color (low bit up)
  logic                  m_tuser;        // in_view
  logic                  m_tlast;        // last pixel
  logic                  cfg_wen = 1'b0;
  logic [1:0]            cfg_addr = REG_SCREEN_WIDTH;
  logic [DEPTH_BITS-1:0] cfg_wdata = '0;

  int failures, pending;

  // local copy of the clip limits, only to aim coordinates at the edges
  int view_w = SCREEN_WIDTH_RST;
  int view_h = SCREEN_HEIGHT_RST;
  int near_z = DEPTH_NEAR_RST;
  int far_z  = DEPTH_FAR_RST;

  int burst_left  = 0;
  int line_left   = 0;  // pixels still owed by the current line
  int phase_count = 0;  // items that matter to the block in this phase
  int quiet       = 0;
  logic [11:0] rx_tick = '0;

  always #2 clk = ~clk;

  line_rasterizer_3d_top #(.COORD_BITS(16)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  line_rasterizer_3d_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .failures(failures), .pending(pending)
  );

  // Consumer: the stall style changes with the upper bits of a free-running tick, with
  // always-ready stretches, coin flips, heavy and light random stalls and fixed patterns.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    case (rx_tick[11:9])
      3'd0, 3'd1: m_tready <= 1'b1;
      3'd2, 3'd3: m_tready <= ($urandom_range(0, 1) == 0);
      3'd4:       m_tready <= ($urandom_range(0, 3) == 0);
      3'd5:       m_tready <= rx_tick[2];
      3'd6:       m_tready <= (rx_tick[3:0] != 4'd0);
      default:    m_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Watchdog: any handshake or config write counts as progress.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic int fit_coord(int v);
    if (v > 32767)  return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Near the clip edges, in a band around the screen, or anywhere in the 16-bit range.
  function automatic int pick_coord(int lo_edge, int hi_edge);
    case ($urandom_range(0, 4))
      0:       return fit_coord(lo_edge + int'($urandom_range(0, 10)) - 5);
      1:       return fit_coord(hi_edge + int'($urandom_range(0, 10)) - 5);
      2:       return int'($urandom_range(0, 4200)) - 50;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // One item on the input stream; bursts of random length, random gaps.
  // Returns right after the accepting edge with tvalid still high.
  task issue(input cmd_t kind, input logic [127:0] payload);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= payload;
    do @(posedge clk); while (!s_tready);
  endtask

  task send_start(input int sx, input int sy, input int sz,
                  input int ex, input int ey, input int ez, input logic [31:0] argb);
    int ax, ay, az, len;
    ax  = (ex > sx) ? ex - sx : sx - ex;
    ay  = (ey > sy) ? ey - sy : sy - ey;
    az  = (ez > sz) ? ez - sz : sz - ez;
    len = ax;
    if (ay > len) len = ay;
    if (az > len) len = az;
    issue(CMD_START, {argb, 16'(ez), 16'(ey), 16'(ex), 16'(sz), 16'(sy), 16'(sx)});
    line_left = len + 1;
    phase_count++;
  endtask

  // payload is don't-care on a next item, so fill it with noise
  task send_next();
    issue(CMD_NEXT, {$urandom, $urandom, $urandom, $urandom});
    if (line_left > 0) begin
      line_left--;
      phase_count++;
    end
  endtask

  // Stop sending until every pixel owed has come out, then let the pipe settle.
  task drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Writes all four clip registers on back-to-back edges; block must be idle.
  task program_view(input int w, input int h, input int n, input int f);
    int vals [4];
    vals = '{w, h, n, f};
    for (int i = 0; i < 4; i++) begin
      cfg_wen   <= 1'b1;
      cfg_addr  <= 2'(i);
      cfg_wdata <= DEPTH_BITS'(vals[i]);
      @(posedge clk);
    end
    cfg_wen <= 1'b0;
    view_w = w;
    view_h = h;
    near_z = n;
    far_z  = f;
  endtask

  // Well-formed line near the clip edges, sometimes cut short by the
  // next start, sometimes followed by a next with no line in progress.
  task random_line();
    int sx, sy, sz, reach, owed;
    sx    = pick_coord(0, view_w);
    sy    = pick_coord(0, view_h);
    sz    = pick_coord(near_z, far_z);
    reach = ($urandom_range(0, 7) == 0) ? 40 : 6;
    send_start(sx, sy, sz,
               fit_coord(sx + int'($urandom_range(0, 2*reach)) - reach),
               fit_coord(sy + int'($urandom_range(0, 2*reach)) - reach),
               fit_coord(sz + int'($urandom_range(0, 2*reach)) - reach),
               $urandom);
    owed = line_left;
    if ($urandom_range(0, 4) == 0) owed = $urandom_range(0, owed - 1);
    repeat (owed) send_next();
    if ($urandom_range(0, 9) == 0) send_next();
  endtask

  // Noise: stray nexts, or a full-range start that is soon replaced.
  task random_noise();
    if ($urandom_range(0, 1) == 0) begin
      send_next();
    end else begin
      send_start(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                 int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                 int'($signed(16'($urandom))), int'($signed(16'($urandom))), $urandom);
      repeat ($urandom_range(0, 3)) send_next();
    end
  endtask

  // clip settings per random phase: zero screen, one pixel, wide screen,
  // full 13-bit width, near above far, small window
  int ph_w [6] = '{0, 1, 4096, 8191, 64, 40};
  int ph_h [6] = '{0, 1, 4096, 8191, 48, 30};
  int ph_n [6] = '{0, 0, 32767, 0, 20, 0};
  int ph_f [6] = '{32767, 0, 32767, 32767, 10, 50};

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part, reset clip limits (800 x 800, depth 1..100) ----
    send_next();                                              // nothing to step
    send_start(5, 5, 5, 5, 5, 5, 32'hFFFF_FFFF);              // single-pixel line
    send_next();
    send_next();                                              // after last: ignored
    send_start(799, 0, 100, 802, 3, 103, 32'h1234_5678);      // three-way tie, x major
    repeat (4) send_next();                                   // crosses x and far edges
    send_start(-1, -1, 1, 0, 1, -1, 32'h8000_0001);           // y ties z, y major
    repeat (3) send_next();
    send_start(-32768, -32768, -32768, 32767, 32767, 32767, 32'h0);  // longest line
    repeat (2) send_next();
    send_start(32767, 0, 0, -32768, 5, 2, 32'hA5A5_5A5A);     // replaces it, steps down
    send_next();
    send_start(0, 799, 0, 1, 800, -4, 32'h00FF_FF00);         // z major
    repeat (5) send_next();
    drain();

    // ---- random part, one clip setting per phase ----
    for (int p = 0; p < 6; p++) begin
      program_view(ph_w[p], ph_h[p], ph_n[p], ph_f[p]);
      line_left   = 0;
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) random_noise();
        else                           random_line();
      end
      drain();
    end

    if (failures == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/lr3_pkg.sv
rtl/core/lr3_setup.sv
rtl/core/lr3_step.sv
rtl/core/line_rasterizer_3d_top.sv
tb/line_rasterizer_3d_checker.sv
tb/testbench.sv
